// ===== rtl/tvw_pkg.sv =====
// tvw_pkg: table sizes, index widths, status codes and ieee equality helpers
// for the triangle vertex welder; no dependencies
package tvw_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_NORMALS  = 4096;
    localparam int MAX_FACETS   = 4096;

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int NIDX_W = $clog2(MAX_NORMALS);
    localparam int FIDX_W = $clog2(MAX_FACETS);

    localparam int VFILL_W = $clog2(MAX_VERTICES + 1);
    localparam int NFILL_W = $clog2(MAX_NORMALS + 1);
    localparam int FFILL_W = $clog2(MAX_FACETS + 1);

    localparam int SCAN_W = (VFILL_W > NFILL_W) ?
        ((VFILL_W > FFILL_W) ? VFILL_W : FFILL_W) :
        ((NFILL_W > FFILL_W) ? NFILL_W : FFILL_W);

    localparam int WORD_W    = 32;
    localparam int VEC_W     = 3 * WORD_W;
    localparam int FACET_W   = 3 * VIDX_W;
    localparam int OUT_IDX_W = 12;
    localparam int CNT_W     = 16;

    typedef logic [1:0] t_status;
    localparam t_status ST_ADDED      = 2'd0;
    localparam t_status ST_DEGENERATE = 2'd1;
    localparam t_status ST_DUPLICATE  = 2'd2;
    localparam t_status ST_OVERFLOW   = 2'd3;

    localparam logic [WORD_W-1:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [WORD_W-1:0] MANT_MASK = 32'h007F_FFFF;
    localparam logic [WORD_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;

    // ieee single equality: nan never equal, signed zeros equal
    function automatic logic word_eq(input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] q);
        logic p_nan;
        logic q_nan;
        p_nan = ((p & EXP_MASK) == EXP_MASK) && ((p & MANT_MASK) != '0);
        q_nan = ((q & EXP_MASK) == EXP_MASK) && ((q & MANT_MASK) != '0);
        if (p_nan || q_nan) begin
            return 1'b0;
        end
        if (((p | q) & MAG_MASK) == '0) begin
            return 1'b1;
        end
        return p == q;
    endfunction

    function automatic logic vec_eq(input logic [VEC_W-1:0] p, input logic [VEC_W-1:0] q);
        return word_eq(p[WORD_W-1:0], q[WORD_W-1:0])
            && word_eq(p[2*WORD_W-1:WORD_W], q[2*WORD_W-1:WORD_W])
            && word_eq(p[3*WORD_W-1:2*WORD_W], q[3*WORD_W-1:2*WORD_W]);
    endfunction

endpackage

// ===== rtl/tvw_ram.sv =====
// tvw_ram: simple dual port synchronous ram, one write and one registered read
// no dependencies
module tvw_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/triangle_vertex_welder.sv =====
// triangle_vertex_welder: one triangle per transaction, welded into vertex,
// normal and facet tables held in three tvw_ram instances
// depends on tvw_pkg and tvw_ram
//
// Input channel: i_valid / o_ready with twelve 32-bit ieee single words
// (three vertices and a facet normal). Output channel: o_valid / i_ready with
// status, indices, insert flags and three saturating running counters.
// Each transaction is handled alone. The vertex and normal rams are swept
// together, one entry per cycle, over max(vertex fill, normal fill) entries;
// if the triangle is not degenerate and all three vertices are known, the
// facet ram is swept over its fill. Then up to three vertex writes follow,
// and the normal and facet writes are made together.
// The result sits in an output register; a new triangle can be taken while
// it waits. If the receiver still stalls when the next result is ready, the
// block holds that result and takes no input until the register frees.
// Reset empties all tables (fill counts go to zero) and clears the counters;
// no clearing pass is needed.
module triangle_vertex_welder
    import tvw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_W-1:0]    i_a_x,
    input  logic [WORD_W-1:0]    i_a_y,
    input  logic [WORD_W-1:0]    i_a_z,
    input  logic [WORD_W-1:0]    i_b_x,
    input  logic [WORD_W-1:0]    i_b_y,
    input  logic [WORD_W-1:0]    i_b_z,
    input  logic [WORD_W-1:0]    i_c_x,
    input  logic [WORD_W-1:0]    i_c_y,
    input  logic [WORD_W-1:0]    i_c_z,
    input  logic [WORD_W-1:0]    i_norm_x,
    input  logic [WORD_W-1:0]    i_norm_y,
    input  logic [WORD_W-1:0]    i_norm_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [OUT_IDX_W-1:0] o_index_a,
    output logic [OUT_IDX_W-1:0] o_index_b,
    output logic [OUT_IDX_W-1:0] o_index_c,
    output logic [OUT_IDX_W-1:0] o_normal_index,
    output logic [OUT_IDX_W-1:0] o_facet_index,
    output logic [1:0]           o_new_vertex_count,
    output logic                 o_normal_was_new,
    output logic [CNT_W-1:0]     o_shared_vertex_total,
    output logic [CNT_W-1:0]     o_shared_normal_total,
    output logic [CNT_W-1:0]     o_dropped_total
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCANV, S_SCANF, S_DECIDE, S_WRV, S_WRF, S_DONE
    } t_state;

    t_state r_state;

    logic [VEC_W-1:0]   r_v [3];
    logic [VEC_W-1:0]   r_n;
    logic [2:0]         r_found;
    logic [VIDX_W-1:0]  r_idx [3];
    logic               r_nfound;
    logic [NIDX_W-1:0]  r_nidx;
    logic               r_dup;
    logic [SCAN_W-1:0]  r_scan;
    logic [SCAN_W-1:0]  r_lim;
    logic               r_cmp_vld;
    logic [SCAN_W-1:0]  r_cmp_idx;
    logic [1:0]         r_wk;
    logic [1:0]         r_newv;
    t_status            r_status;
    logic [FIDX_W-1:0]  r_fpos;

    logic [VFILL_W-1:0] r_vfill;
    logic [NFILL_W-1:0] r_nfill;
    logic [FFILL_W-1:0] r_ffill;
    logic [CNT_W-1:0]   r_shv;
    logic [CNT_W-1:0]   r_shn;
    logic [CNT_W-1:0]   r_drop;

    // ram ports
    logic               v_we;
    logic [VIDX_W-1:0]  v_waddr;
    logic [VEC_W-1:0]   v_rdata;
    logic               n_we;
    logic [VEC_W-1:0]   n_rdata;
    logic               f_we;
    logic [FACET_W-1:0] f_rdata;

    logic               deg;
    logic [1:0]         need;
    logic [1:0]         nshared;
    logic               all_found;
    logic               scan_end;
    logic               rot_hit;
    logic [VIDX_W-1:0]  f0, f1, f2;
    logic [SCAN_W-1:0]  vfill_s, nfill_s, ffill_s;
    logic               vfull, nfull, ffull;
    logic [CNT_W:0]     shv_sum, shn_sum, drop_sum;

    assign vfill_s = SCAN_W'(r_vfill);
    assign nfill_s = SCAN_W'(r_nfill);
    assign ffill_s = SCAN_W'(r_ffill);

    assign deg = vec_eq(r_v[0], r_v[1]) || vec_eq(r_v[1], r_v[2]) || vec_eq(r_v[0], r_v[2]);
    assign all_found = &r_found;
    assign nshared = 2'(r_found[0]) + 2'(r_found[1]) + 2'(r_found[2]);
    assign need = 2'd3 - nshared;
    assign scan_end = (r_scan >= r_lim) && !r_cmp_vld;

    // capacity checks
    assign vfull = ((VFILL_W + 1)'(r_vfill) + (VFILL_W + 1)'(need)) > (VFILL_W + 1)'(MAX_VERTICES);
    assign nfull = !r_nfound && (r_nfill >= NFILL_W'(MAX_NORMALS));
    assign ffull = r_ffill >= FFILL_W'(MAX_FACETS);

    // stored facet against the three rotations of the new one
    assign f0 = f_rdata[VIDX_W-1:0];
    assign f1 = f_rdata[2*VIDX_W-1:VIDX_W];
    assign f2 = f_rdata[3*VIDX_W-1:2*VIDX_W];
    assign rot_hit = (f0 == r_idx[0] && f1 == r_idx[1] && f2 == r_idx[2])
                  || (f1 == r_idx[0] && f2 == r_idx[1] && f0 == r_idx[2])
                  || (f2 == r_idx[0] && f0 == r_idx[1] && f1 == r_idx[2]);

    // saturating counter sums
    assign shv_sum  = (CNT_W + 1)'(r_shv) + (CNT_W + 1)'(nshared);
    assign shn_sum  = (CNT_W + 1)'(r_shn) + (CNT_W + 1)'(1);
    assign drop_sum = (CNT_W + 1)'(r_drop) + (CNT_W + 1)'(1);

    assign v_we    = (r_state == S_WRV) && (r_wk != 2'd3) && !r_found[r_wk];
    assign v_waddr = VIDX_W'(r_vfill);
    assign n_we    = (r_state == S_WRF) && !r_nfound;
    assign f_we    = (r_state == S_WRF);

    assign o_ready = (r_state == S_IDLE);

    tvw_ram #(.DATA_W(VEC_W), .ADDR_W(VIDX_W)) u_vram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (r_v[r_wk[1] ? 2'd2 : r_wk]),
        .i_raddr (r_scan[VIDX_W-1:0]),
        .o_rdata (v_rdata)
    );

    tvw_ram #(.DATA_W(VEC_W), .ADDR_W(NIDX_W)) u_nram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (NIDX_W'(r_nfill)),
        .i_wdata (r_n),
        .i_raddr (r_scan[NIDX_W-1:0]),
        .o_rdata (n_rdata)
    );

    tvw_ram #(.DATA_W(FACET_W), .ADDR_W(FIDX_W)) u_fram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (FIDX_W'(r_ffill)),
        .i_wdata ({r_idx[2], r_idx[1], r_idx[0]}),
        .i_raddr (r_scan[FIDX_W-1:0]),
        .o_rdata (f_rdata)
    );

    // sequencer: scan, decide, write back, present result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vfill   <= '0;
            r_nfill   <= '0;
            r_ffill   <= '0;
            r_shv     <= '0;
            r_shn     <= '0;
            r_drop    <= '0;
            r_cmp_vld <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            // output register frees on acceptance unless refilled below
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v[0]    <= {i_a_z, i_a_y, i_a_x};
                        r_v[1]    <= {i_b_z, i_b_y, i_b_x};
                        r_v[2]    <= {i_c_z, i_c_y, i_c_x};
                        r_n       <= {i_norm_z, i_norm_y, i_norm_x};
                        r_found   <= '0;
                        r_nfound  <= 1'b0;
                        r_dup     <= 1'b0;
                        r_idx[0]  <= '0;
                        r_idx[1]  <= '0;
                        r_idx[2]  <= '0;
                        r_nidx    <= '0;
                        r_newv    <= '0;
                        r_fpos    <= '0;
                        r_scan    <= '0;
                        r_lim     <= (vfill_s > nfill_s) ? vfill_s : nfill_s;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SCANV;
                    end
                end
                S_SCANV: begin
                    if (r_scan < r_lim) begin
                        r_scan    <= r_scan + 1'b1;
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_scan;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    // first match wins for each vertex and the normal
                    if (r_cmp_vld) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_cmp_idx < vfill_s && !r_found[k]
                                && vec_eq(v_rdata, r_v[k])) begin
                                r_found[k] <= 1'b1;
                                r_idx[k]   <= VIDX_W'(r_cmp_idx);
                            end
                        end
                        if (r_cmp_idx < nfill_s && !r_nfound && vec_eq(n_rdata, r_n)) begin
                            r_nfound <= 1'b1;
                            r_nidx   <= NIDX_W'(r_cmp_idx);
                        end
                    end
                    if (scan_end) begin
                        r_scan <= '0;
                        r_lim  <= ffill_s;
                        if (!deg && all_found) begin
                            r_state <= S_SCANF;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_SCANF: begin
                    if (r_scan < r_lim) begin
                        r_scan    <= r_scan + 1'b1;
                        r_cmp_vld <= 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && rot_hit) begin
                        r_dup <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (deg || r_dup) begin
                        r_status <= deg ? ST_DEGENERATE : ST_DUPLICATE;
                        r_drop   <= drop_sum[CNT_W] ? '1 : drop_sum[CNT_W-1:0];
                        r_state  <= S_DONE;
                    end else if (vfull || nfull || ffull) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_DONE;
                    end else begin
                        r_status <= ST_ADDED;
                        r_shv    <= shv_sum[CNT_W] ? '1 : shv_sum[CNT_W-1:0];
                        r_fpos   <= FIDX_W'(r_ffill);
                        r_wk     <= '0;
                        r_state  <= S_WRV;
                    end
                end
                S_WRV: begin
                    // append missing vertices one per cycle
                    if (r_wk == 2'd3) begin
                        r_state <= S_WRF;
                    end else begin
                        if (!r_found[r_wk]) begin
                            r_idx[r_wk] <= VIDX_W'(r_vfill);
                            r_vfill     <= r_vfill + 1'b1;
                            r_newv      <= r_newv + 1'b1;
                        end
                        r_wk <= r_wk + 1'b1;
                    end
                end
                S_WRF: begin
                    if (!r_nfound) begin
                        r_nidx  <= NIDX_W'(r_nfill);
                        r_nfill <= r_nfill + 1'b1;
                    end else begin
                        r_shn <= shn_sum[CNT_W] ? '1 : shn_sum[CNT_W-1:0];
                    end
                    r_ffill <= r_ffill + 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid               <= 1'b1;
                        o_status              <= r_status;
                        o_shared_vertex_total <= r_shv;
                        o_shared_normal_total <= r_shn;
                        o_dropped_total       <= r_drop;
                        if (r_status == ST_ADDED) begin
                            o_index_a          <= OUT_IDX_W'(r_idx[0]);
                            o_index_b          <= OUT_IDX_W'(r_idx[1]);
                            o_index_c          <= OUT_IDX_W'(r_idx[2]);
                            o_normal_index     <= OUT_IDX_W'(r_nidx);
                            o_facet_index      <= OUT_IDX_W'(r_fpos);
                            o_new_vertex_count <= r_newv;
                            o_normal_was_new   <= !r_nfound;
                        end else begin
                            o_index_a          <= '0;
                            o_index_b          <= '0;
                            o_index_c          <= '0;
                            o_normal_index     <= '0;
                            o_facet_index      <= '0;
                            o_new_vertex_count <= '0;
                            o_normal_was_new   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // vertex and facet fill counts never pass their table depth
    a_vfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vfill <= VFILL_W'(MAX_VERTICES))
        else $error("vertex fill beyond table depth");

    a_ffill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ffill <= FFILL_W'(MAX_FACETS))
        else $error("facet fill beyond table depth");

    // a vertex write always lands on the next free entry and advances the fill
    a_vwrite_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_we |=> r_vfill == $past(r_vfill) + 1'b1)
        else $error("vertex write without fill advance");

    // an accepted triangle leaves the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken twice in a row");

endmodule
